// ===== design/gcr_pkg.sv =====
// Shared types, constants and the 6-and-2 code table of the GCR sector decoder.
package gcr_pkg;

    localparam logic [7:0] MARK_D5 = 8'hD5;
    localparam logic [7:0] MARK_AA = 8'hAA;
    localparam logic [7:0] MARK_96 = 8'h96;
    localparam logic [7:0] MARK_AD = 8'hAD;

    localparam int AUX_COUNT   = 86;
    localparam int FIELD_LAST  = 341;
    localparam int ADDR_LAST   = 10;
    localparam int AUX_IDX_W   = 7;

    localparam logic [0:0] CFG_TARGET_TRACK = 1'b0;
    localparam logic [0:0] CFG_DATA_WINDOW  = 1'b1;

    localparam logic [7:0] DATA_WINDOW_RESET = 8'd100;

    localparam logic [7:0] GCR_CODES [64] = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

    typedef struct packed {
        logic [7:0] nibble;
        logic       track_start;
        logic       code_ok;
        logic [5:0] code_val;
    } t_item;

    function automatic logic [6:0] gcr_decode(input logic [7:0] b);
        logic [6:0] res;
        res = 7'd0;
        for (int k = 0; k < 64; k++) begin
            if (GCR_CODES[k] == b) begin
                res = {1'b1, 6'(k)};
            end
        end
        return res;
    endfunction

endpackage

// ===== design/gcr_sector_stream_decoder.sv =====
// Top level: configuration registers and the front queue joined to the decoding back end.
// A nibble accepted into the queue is taken by the back end once the output register
// can accept; its data byte is then registered in the output register behind tvalid.
// Throughput: one nibble per cycle unless the output stalls, set by the back-end update.
// A two-word queue decouples input from back-end stalls on the master side.
// Reset (synchronous, active low) empties the queue and output register, returns to
// the address hunt at track position zero and sets data_window to 100, target_track to 0.
module gcr_sector_stream_decoder
    import gcr_pkg::*;
#(
    parameter int TRACK_BYTES = 6656
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // nibble
    input  logic        s_axis_tuser,   // track_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // data_byte, byte_index, sector_number, volume_number
    output logic        m_axis_tuser,   // sector_good
    output logic        m_axis_tlast    // last
);

    logic [7:0] r_target_track;
    logic [7:0] r_data_window;
    logic       w_q_valid;
    logic       w_pop;
    t_item      w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_track <= '0;
            r_data_window  <= DATA_WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TARGET_TRACK: r_target_track <= i_cfg_data;
                CFG_DATA_WINDOW:  r_data_window  <= i_cfg_data;
                default:          r_data_window  <= r_data_window;
            endcase
        end
    end

    gcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_nibble      (s_axis_tdata),
        .i_track_start (s_axis_tuser),
        .o_valid       (w_q_valid),
        .i_pop         (w_pop),
        .o_item        (w_item)
    );

    gcr_back #(
        .TRACK_BYTES (TRACK_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_target_track (r_target_track),
        .i_data_window  (r_data_window),
        .i_valid        (w_q_valid),
        .i_item         (w_item),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_data         (m_axis_tdata),
        .o_good         (m_axis_tuser),
        .o_last         (m_axis_tlast)
    );

endmodule

// ===== design/gcr_front.sv =====
// Front end: decode each nibble against the code table and queue it for the back end.
module gcr_front
    import gcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_nibble,
    input  logic       i_track_start,
    output logic       o_valid,
    input  logic       i_pop,
    output t_item      o_item
);

    t_item      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic [6:0] w_dec;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_dec   = gcr_decode(i_nibble);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{nibble: i_nibble, track_start: i_track_start,
                           code_ok: w_dec[6], code_val: w_dec[5:0]};
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == 2'd0))
        else $error("pop from empty queue");

endmodule

// ===== design/gcr_back.sv =====
// Back end: prologue hunt, address and data field decode, aux memory and output register.
module gcr_back
    import gcr_pkg::*;
#(
    parameter int TRACK_BYTES = 6656
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_target_track,
    input  logic [7:0]  i_data_window,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data,
    output logic        o_good,
    output logic        o_last
);

    localparam int PW = $clog2(TRACK_BYTES + 1);
    localparam logic [PW-1:0] POS_MAX   = PW'(TRACK_BYTES);
    localparam logic [PW-1:0] POS_ADDR  = PW'(TRACK_BYTES - 12);
    localparam logic [PW-1:0] POS_DMARK = PW'(TRACK_BYTES - 1);
    localparam logic [PW-1:0] POS_FIT   = PW'(TRACK_BYTES - 344);
    localparam logic [PW-1:0] POS_HUNT  = PW'(TRACK_BYTES - 400);
    localparam logic [PW-1:0] POS_HUNT1 = PW'(TRACK_BYTES - 401);

    typedef enum logic [2:0] {
        PH_HUNT, PH_ADDR, PH_SEEK, PH_DATA, PH_CSUM, PH_IDLE
    } t_phase;

    t_phase                r_phase, n_phase, w_phase;
    logic [15:0]           r_hist, n_hist, w_hist;
    logic [8:0]            r_fc, n_fc;
    logic [8:0]            r_win, n_win;
    logic [PW-1:0]         r_pos, n_pos, w_p;
    logic [7:0]            r_pair, n_pair;
    logic [7:0]            r_vol, n_vol;
    logic [7:0]            r_trk, n_trk;
    logic [7:0]            r_sec, n_sec;
    logic [5:0]            r_chain, n_chain;
    logic                  r_bad, n_bad;
    logic [AUX_IDX_W-1:0]  r_idx, n_idx;
    logic [1:0]            r_sh, n_sh;
    logic [5:0]            r_aux_mem [AUX_COUNT];
    logic [5:0]            r_aux_q;
    logic                  w_aux_we;
    logic                  w_emit;
    logic [31:0]           w_data;
    logic                  w_good;
    logic                  w_last;
    logic [7:0]            w_pv;
    logic [5:0]            w_c;
    logic [1:0]            w_abits;
    logic [8:0]            w_fi;
    logic                  w_match;
    logic                  w_out_rdy;
    logic                  r_ov;
    logic [31:0]           r_data;
    logic                  r_good;
    logic                  r_last;

    assign w_out_rdy = !r_ov || i_ready;
    assign o_pop     = i_valid && w_out_rdy;
    assign o_valid   = r_ov;
    assign o_data    = r_data;
    assign o_good    = r_good;
    assign o_last    = r_last;

    always_comb begin
        w_phase  = i_item.track_start ? PH_HUNT : r_phase;
        w_hist   = i_item.track_start ? 16'd0 : r_hist;
        w_p      = i_item.track_start ? '0 : r_pos;
        n_pos    = (w_p < POS_MAX) ? w_p + PW'(1) : w_p;
        n_phase  = w_phase;
        n_hist   = w_hist;
        n_fc     = r_fc;
        n_win    = r_win;
        n_pair   = r_pair;
        n_vol    = r_vol;
        n_trk    = r_trk;
        n_sec    = r_sec;
        n_chain  = r_chain;
        n_bad    = r_bad;
        n_idx    = r_idx;
        n_sh     = r_sh;
        w_aux_we = 1'b0;
        w_emit   = 1'b0;
        w_pv     = {r_pair[6:0], 1'b1} & i_item.nibble;
        w_c      = i_item.code_val ^ r_chain;
        w_fi     = r_fc - 9'(AUX_COUNT);
        case (r_sh)
            2'd1:    w_abits = r_aux_q[1:0];
            2'd2:    w_abits = r_aux_q[3:2];
            default: w_abits = r_aux_q[5:4];
        endcase
        w_data   = {r_vol, r_sec, w_fi[7:0], w_c, w_abits};
        w_last   = (r_fc == 9'(FIELD_LAST));
        w_good   = w_last && !(r_bad || !i_item.code_ok);
        w_match  = (r_win >= 9'd2) && (w_hist == {MARK_D5, MARK_AA})
                   && (i_item.nibble == MARK_AD)
                   && ((r_win - 9'd2) < {1'b0, i_data_window})
                   && (w_p >= PW'(2)) && (w_p < POS_DMARK);

        case (w_phase)
            PH_HUNT: begin
                if (w_hist == {MARK_D5, MARK_AA} && i_item.nibble == MARK_96
                        && w_p < POS_ADDR) begin
                    n_phase = PH_ADDR;
                    n_fc    = '0;
                    n_hist  = '0;
                end else begin
                    n_hist = {w_hist[7:0], i_item.nibble};
                end
            end
            PH_ADDR: begin
                if (r_fc[0]) begin
                    if (r_fc == 9'd1) n_vol = w_pv;
                    if (r_fc == 9'd3) n_trk = w_pv;
                    if (r_fc == 9'd5) n_sec = w_pv;
                end else begin
                    n_pair = i_item.nibble;
                end
                if (r_fc >= 9'(ADDR_LAST)) begin
                    n_hist = '0;
                    if (r_trk != i_target_track) begin
                        n_phase = (w_p < POS_HUNT1) ? PH_HUNT : PH_IDLE;
                    end else begin
                        n_phase = PH_SEEK;
                        n_win   = '0;
                    end
                end else begin
                    n_fc = r_fc + 9'd1;
                end
            end
            PH_SEEK: begin
                if (w_match && w_p <= POS_FIT) begin
                    n_phase = PH_DATA;
                    n_fc    = '0;
                    n_chain = '0;
                    n_bad   = 1'b0;
                    n_idx   = '0;
                    n_sh    = '0;
                end else if (w_match || r_win >= {1'b0, i_data_window} + 9'd1) begin
                    n_hist  = {8'd0, i_item.nibble};
                    n_phase = (w_p < POS_HUNT) ? PH_HUNT : PH_IDLE;
                end else begin
                    n_hist = {w_hist[7:0], i_item.nibble};
                    n_win  = r_win + 9'd1;
                end
            end
            PH_DATA: begin
                n_chain = w_c;
                n_bad   = r_bad || !i_item.code_ok;
                if (r_sh == 2'd0) w_aux_we = 1'b1;
                else              w_emit   = 1'b1;
                if (r_idx == AUX_IDX_W'(AUX_COUNT - 1)) begin
                    n_idx = '0;
                    n_sh  = r_sh + 2'd1;
                end else begin
                    n_idx = r_idx + AUX_IDX_W'(1);
                end
                if (r_fc >= 9'(FIELD_LAST)) n_phase = PH_CSUM;
                else                        n_fc    = r_fc + 9'd1;
            end
            PH_CSUM: begin
                n_hist  = '0;
                n_phase = (w_p < POS_HUNT1) ? PH_HUNT : PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_aux_we) begin
            r_aux_mem[r_idx] <= w_c;
        end
        r_aux_q <= r_aux_mem[o_pop ? n_idx : r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && o_pop && w_emit) begin
            r_data <= w_data;
            r_good <= w_good;
            r_last <= w_last;
        end
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_hist  <= '0;
            r_fc    <= '0;
            r_win   <= '0;
            r_pos   <= '0;
            r_pair  <= '0;
            r_vol   <= '0;
            r_trk   <= '0;
            r_sec   <= '0;
            r_chain <= '0;
            r_bad   <= 1'b0;
            r_idx   <= '0;
            r_sh    <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_out_rdy) r_ov <= o_pop && w_emit;
            if (o_pop) begin
                r_phase <= n_phase;
                r_hist  <= n_hist;
                r_fc    <= n_fc;
                r_win   <= n_win;
                r_pos   <= n_pos;
                r_pair  <= n_pair;
                r_vol   <= n_vol;
                r_trk   <= n_trk;
                r_sec   <= n_sec;
                r_chain <= n_chain;
                r_bad   <= n_bad;
                r_idx   <= n_idx;
                r_sh    <= n_sh;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < AUX_IDX_W'(AUX_COUNT))
        else $error("aux index out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA && r_sh == 2'd0) |-> (r_fc == 9'(r_idx)))
        else $error("aux index out of step with field count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_item.track_start && r_phase == PH_DATA
         && r_fc == 9'(FIELD_LAST)) |=> (r_phase == PH_CSUM && r_ov && r_last))
        else $error("last data byte not emitted");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_good) |-> r_last)
        else $error("good flag on a byte other than the last");

endmodule

// ===== bench/gcr_sector_stream_decoder_test.sv =====
// Testbench for the GCR sector stream decoder: directed rows and random tracks against a predictor.
module gcr_sector_stream_decoder_test;
    import gcr_pkg::*;

    localparam int TRK = 6656;
    localparam int ADDR_MARK_LIMIT = TRK - 12;
    localparam int DATA_MARK_LIMIT = TRK - 3;
    localparam int DATA_FIT = 344;
    localparam int RESUME_LIMIT = TRK - 400;

    typedef enum logic [2:0] {
        ST_HUNT, ST_ADDR, ST_SEEK, ST_DATA, ST_CSUM, ST_IDLE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] sector_number;
        logic [7:0] volume_number;
        logic       sector_good;
        logic       last;
    } t_sector_byte;

    typedef struct packed {
        logic [7:0] nibble;
        logic       track_start;
        logic       has_byte;
        logic [7:0] want_byte;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_addr;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // nibble
    logic        s_axis_tuser;   // track_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // data_byte, byte_index, sector_number, volume_number
    logic        m_axis_tuser;   // sector_good
    logic        m_axis_tlast;   // last

    gcr_sector_stream_decoder i_dut (.*);

    // predictor state
    logic [7:0]  cfg_track;
    logic [7:0]  cfg_window;
    t_phase      ph;
    logic [15:0] hist;
    int          fcount;
    int          wcount;
    int          tpos;
    logic [7:0]  pfirst;
    logic [7:0]  a_vol;
    logic [7:0]  a_trk;
    logic [7:0]  a_sec;
    logic [5:0]  aux [86];
    logic [5:0]  chain;
    logic        bad;

    t_sector_byte expected_bytes [$];
    int  mismatches;
    int  bytes_seen;
    int  sectors_seen;
    int  nibbles_sent;
    bit  hold_off;
    bit  stim_done;

    function automatic logic [6:0] code_of(input logic [7:0] b);
        for (int k = 0; k < 64; k++) begin
            if (GCR_CODES[k] == b) begin
                return {1'b1, 6'(k)};
            end
        end
        return 7'd0;
    endfunction

    function automatic void resume_hunt_at(input int pos, input logic [15:0] h);
        hist = h;
        ph = (pos < RESUME_LIMIT) ? ST_HUNT : ST_IDLE;
    endfunction

    function automatic void decode_nibble(input logic [7:0] nib, input logic ts);
        int p;
        int w;
        int i;
        logic [6:0] cv;
        logic [5:0] c;
        logic [7:0] v;
        t_sector_byte r;
        if (ts) begin
            tpos = 0;
            ph = ST_HUNT;
            hist = 16'd0;
        end
        p = tpos;
        if (tpos < TRK) tpos++;
        case (ph)
            ST_HUNT: begin
                if (hist == {MARK_D5, MARK_AA} && nib == MARK_96 && p < ADDR_MARK_LIMIT) begin
                    ph = ST_ADDR;
                    fcount = 0;
                    hist = 16'd0;
                end else begin
                    hist = {hist[7:0], nib};
                end
            end
            ST_ADDR: begin
                if (fcount[0]) begin
                    v = {pfirst[6:0], 1'b1} & nib;
                    if (fcount == 1) a_vol = v;
                    else if (fcount == 3) a_trk = v;
                    else if (fcount == 5) a_sec = v;
                end else begin
                    pfirst = nib;
                end
                if (fcount >= ADDR_LAST) begin
                    if (a_trk != cfg_track) begin
                        resume_hunt_at(p + 1, 16'd0);
                    end else begin
                        ph = ST_SEEK;
                        wcount = 0;
                        hist = 16'd0;
                    end
                end else begin
                    fcount++;
                end
            end
            ST_SEEK: begin
                w = wcount;
                if (w >= 2 && hist == {MARK_D5, MARK_AA} && nib == MARK_AD
                        && (w - 2) < int'(cfg_window) && p >= 2
                        && (p - 2) < DATA_MARK_LIMIT) begin
                    if (p + DATA_FIT <= TRK) begin
                        ph = ST_DATA;
                        fcount = 0;
                        chain = 6'd0;
                        bad = 1'b0;
                    end else begin
                        resume_hunt_at(p, {8'd0, nib});
                    end
                end else if (w >= int'(cfg_window) + 1) begin
                    resume_hunt_at(p, {8'd0, nib});
                end else begin
                    hist = {hist[7:0], nib};
                    wcount = w + 1;
                end
            end
            ST_DATA: begin
                cv = code_of(nib);
                if (!cv[6]) bad = 1'b1;
                c = cv[5:0] ^ chain;
                chain = c;
                if (fcount < AUX_COUNT) begin
                    aux[fcount] = c;
                end else begin
                    i = fcount - AUX_COUNT;
                    r.data_byte = {c, 2'(aux[i % AUX_COUNT] >> ((i / AUX_COUNT) * 2))};
                    r.byte_index = 8'(i);
                    r.sector_number = a_sec;
                    r.volume_number = a_vol;
                    r.last = (i == 255);
                    r.sector_good = r.last && !bad;
                    expected_bytes.push_back(r);
                end
                if (fcount >= FIELD_LAST) ph = ST_CSUM;
                else fcount++;
            end
            ST_CSUM: resume_hunt_at(p + 1, 16'd0);
            default: ph = ST_IDLE;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

    // nibble source
    logic [7:0] src_nib [$];
    logic       src_ts [$];

    task automatic push(input logic [7:0] n, input logic ts = 1'b0);
        src_nib.push_back(n);
        src_ts.push_back(ts);
    endtask

    function automatic logic [7:0] rand_code();
        return GCR_CODES[$urandom_range(0, 63)];
    endfunction

    task automatic push_44(input logic [7:0] v);
        push({1'b1, v[7], 1'b1, v[5], 1'b1, v[3], 1'b1, v[1]});
        push({1'b1, v[6], 1'b1, v[4], 1'b1, v[2], 1'b1, v[0]});
    endtask

    // well-formed sector with random content, optional defects
    task automatic push_sector(input logic [7:0] trk, input bit corrupt, input int gap);
        push(MARK_D5); push(MARK_AA); push(MARK_96);
        push_44(8'($urandom)); push_44(trk); push_44(8'($urandom_range(0, 15)));
        push_44(8'($urandom));
        push(8'hDE); push(MARK_AA); push(8'hEB);
        for (int k = 0; k < gap; k++) push(8'hFF);
        push(MARK_D5); push(MARK_AA); push(MARK_AD);
        for (int k = 0; k < 342; k++) begin
            if (corrupt && $urandom_range(0, 99) == 0) push(8'($urandom));
            else push(rand_code());
        end
        push(rand_code()); push(8'hDE); push(MARK_AA); push(8'hEB);
    endtask

    task automatic send_all();
        while (src_nib.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= src_nib[0];
            s_axis_tuser <= src_ts[0];
            do @(posedge i_clk); while (!s_axis_tready);
            decode_nibble(src_nib[0], src_ts[0]);
            void'(src_nib.pop_front());
            void'(src_ts.pop_front());
            nibbles_sent++;
            if ($urandom_range(0, 3) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : 1) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_bytes.size() > 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TARGET_TRACK) cfg_track = val;
        else cfg_window = val;
    endtask

    // output side
    initial begin
        m_axis_tready = 1'b0;
        hold_off = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) m_axis_tready <= 1'b0;
            else if ($urandom_range(0, 4) == 0)
                m_axis_tready <= 1'b0;
            else m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_sector_byte got;
        t_sector_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                   m_axis_tdata[31:24], m_axis_tuser, m_axis_tlast};
            bytes_seen++;
            if (got.last) sectors_seen++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = expected_bytes.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    // directed rows: stray nibbles, prologue at track start, marks outside a field
    t_row directed [] = '{
        '{8'h00, 1'b1, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
        '{MARK_D5, 1'b0, 1'b0, 8'h00}, '{MARK_AA, 1'b0, 1'b0, 8'h00},
        '{MARK_AD, 1'b0, 1'b0, 8'h00}, '{MARK_96, 1'b0, 1'b0, 8'h00},
        '{8'h55, 1'b1, 1'b0, 8'h00}, '{8'hAA, 1'b0, 1'b0, 8'h00},
        '{8'h80, 1'b0, 1'b0, 8'h00}, '{8'h01, 1'b0, 1'b0, 8'h00}
    };

    initial begin
        int k;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_addr = CFG_TARGET_TRACK; i_cfg_data = 8'd0;
        s_axis_tvalid = 1'b0; s_axis_tdata = 8'd0; s_axis_tuser = 1'b0;
        mismatches = 0; bytes_seen = 0; sectors_seen = 0; nibbles_sent = 0;
        cfg_track = 8'd0; cfg_window = DATA_WINDOW_RESET;
        ph = ST_HUNT; hist = 16'd0; fcount = 0; wcount = 0; tpos = 0; pfirst = 8'd0;
        a_vol = 8'd0; a_trk = 8'd0; a_sec = 8'd0; chain = 6'd0; bad = 1'b0;
        foreach (aux[j]) aux[j] = 6'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[j]) push(directed[j].nibble, directed[j].track_start);
        push_sector(8'd0, 1'b0, 5);
        push_sector(8'd0, 1'b1, 0);
        send_all();
        drain();
        if (expected_bytes.size() == 0 && sectors_seen != 2) begin
            mismatches++;
            $display("directed: expected 2 sectors, saw %0d", sectors_seen);
        end

        // long receiver hold-off while the sender keeps going
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                push_sector(8'd0, 1'b0, 2);
                send_all();
            end
        join
        drain();

        for (int phs = 0; phs < 2; phs++) begin
            write_cfg(CFG_TARGET_TRACK, phs == 0 ? 8'd255 : 8'($urandom_range(0, 255)));
            write_cfg(CFG_DATA_WINDOW, phs == 0 ? 8'd1 : 8'd255);
            push(8'($urandom), 1'b1);
            for (int s = 0; s < 1; s++) begin
                k = $urandom_range(0, 9);
                if (k < 7)
                    push_sector(cfg_track, k == 6, $urandom_range(0, int'(cfg_window) + 2));
                else if (k == 7)
                    push_sector(8'($urandom), 1'b0, 2);
                else
                    for (int j = 0; j < 40; j++)
                        push($urandom_range(0, 1) ? 8'($urandom) : MARK_D5,
                             $urandom_range(0, 99) == 0);
            end
            send_all();
            drain();
        end

        if (expected_bytes.size() != 0) begin
            mismatches++;
            $display("%0d data bytes never arrived", expected_bytes.size());
        end
        $display("sent %0d nibbles, checked %0d data bytes in %0d sectors",
                 nibbles_sent, bytes_seen, sectors_seen);
        $display("covered both track and window extremes, corrupted codes and a stalled output");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ===== gcr_sector_stream_decoder.f =====
design/gcr_pkg.sv
design/gcr_front.sv
design/gcr_back.sv
design/gcr_sector_stream_decoder.sv
bench/gcr_sector_stream_decoder_test.sv
